@@ sv/utf8p_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8p_pkg
// Shared types and byte constants for the UTF-8 decoder with position.
// ----------------------------------------------------------------------------
package utf8p_pkg;

   localparam int COUNTER_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH          = 4;   // power of two

   localparam int CP_BITS    = 21;
   localparam int COUNT_BITS = 3;
   localparam int POS_BITS   = 32;

   // byte values used by the decoder
   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_ASCII   = 8'h80;
   localparam logic [7:0] LEAD_MIN     = 8'hc2;
   localparam logic [7:0] LEAD_3B      = 8'he0;
   localparam logic [7:0] LEAD_4B      = 8'hf0;
   localparam logic [7:0] LEAD_LIMIT   = 8'hf5;
   localparam logic [7:0] LEAD_E0      = 8'he0;
   localparam logic [7:0] LEAD_ED      = 8'hed;
   localparam logic [7:0] LEAD_F0      = 8'hf0;
   localparam logic [7:0] LEAD_F4      = 8'hf4;
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hbf;
   localparam logic [7:0] CONT_LO_E0   = 8'ha0;
   localparam logic [7:0] CONT_HI_ED   = 8'h9f;
   localparam logic [7:0] CONT_LO_F0   = 8'h90;
   localparam logic [7:0] CONT_HI_F4   = 8'h8f;

   localparam logic [CP_BITS-1:0] CP_NEWLINE = 21'd10;
   localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10ffff;
   localparam logic [COUNT_BITS-1:0] MAX_SEQ_BYTES = 3'd4;

   // one decoded event passed from the front end to the position tracker
   typedef struct packed {
      logic [CP_BITS-1:0]    code_point;
      logic [COUNT_BITS-1:0] byte_count;
      logic                  malformed;
   } utf8p_event_type;

endpackage

@@ sv/utf8p_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8p_front
// Byte front end: validates strict UTF-8 and assembles code points.
// ----------------------------------------------------------------------------
module utf8p_front
   import utf8p_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   output logic            byte_ready,
   input  logic [7:0]      byte_data,
   input  logic            queue_full,
   output logic            evt_push,
   output utf8p_event_type evt_data
);

   logic [1:0]         rem_ff, rem_in;
   logic [2:0]         total_ff, total_in;
   logic [CP_BITS-1:0] partial_ff, partial_in;
   logic [7:0]         lead_ff, lead_in;
   logic [1:0]         cidx_ff, cidx_in;

   logic               accept;
   logic [7:0]         lo, hi;
   logic [1:0]         rem_dec;
   logic [CP_BITS-1:0] shifted;
   logic [CP_BITS-1:0] partial_new;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;

   always_comb begin
      rem_in      = rem_ff;
      total_in    = total_ff;
      partial_in  = partial_ff;
      lead_in     = lead_ff;
      cidx_in     = cidx_ff;
      evt_push    = 1'b0;
      evt_data    = '0;
      lo          = CONT_LO;
      hi          = CONT_HI;
      rem_dec     = rem_ff - 2'd1;
      case (rem_dec)
         2'd0:    shifted = {15'b0, byte_data[5:0]};
         2'd1:    shifted = {9'b0, byte_data[5:0], 6'b0};
         default: shifted = {3'b0, byte_data[5:0], 12'b0};
      endcase
      partial_new = partial_ff | shifted;

      // second byte range is narrowed by the lead
      if (cidx_ff == 2'd0) begin
         case (lead_ff)
            LEAD_E0: lo = CONT_LO_E0;
            LEAD_ED: hi = CONT_HI_ED;
            LEAD_F0: lo = CONT_LO_F0;
            LEAD_F4: hi = CONT_HI_F4;
            default: ;
         endcase
      end

      if (accept) begin
         if (rem_ff == 2'd0) begin
            if (byte_data == BYTE_NUL) begin
               evt_push           = 1'b1;
               evt_data.malformed = 1'b1;
            end else if (byte_data < BYTE_ASCII) begin
               evt_push            = 1'b1;
               evt_data.code_point = {13'b0, byte_data};
               evt_data.byte_count = 3'd1;
            end else if (byte_data < LEAD_MIN || byte_data >= LEAD_LIMIT) begin
               evt_push           = 1'b1;
               evt_data.malformed = 1'b1;
            end else begin
               lead_in = byte_data;
               cidx_in = 2'd0;
               if (byte_data < LEAD_3B) begin
                  total_in   = 3'd2;
                  rem_in     = 2'd1;
                  partial_in = {10'b0, byte_data[4:0], 6'b0};
               end else if (byte_data < LEAD_4B) begin
                  total_in   = 3'd3;
                  rem_in     = 2'd2;
                  partial_in = {5'b0, byte_data[3:0], 12'b0};
               end else begin
                  total_in   = 3'd4;
                  rem_in     = 2'd3;
                  partial_in = {byte_data[2:0], 18'b0};
               end
            end
         end else if (byte_data < lo || byte_data > hi) begin
            // bad continuation: drop the partial character, byte is consumed
            evt_push           = 1'b1;
            evt_data.malformed = 1'b1;
            rem_in             = '0;
            total_in           = '0;
            partial_in         = '0;
            lead_in            = '0;
            cidx_in            = '0;
         end else if (rem_dec == 2'd0) begin
            evt_push            = 1'b1;
            evt_data.code_point = partial_new;
            evt_data.byte_count = total_ff;
            rem_in              = '0;
            total_in            = '0;
            partial_in          = '0;
            lead_in             = '0;
            cidx_in             = '0;
         end else begin
            rem_in     = rem_dec;
            partial_in = partial_new;
            cidx_in    = cidx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         total_ff   <= '0;
         partial_ff <= '0;
         lead_ff    <= '0;
         cidx_ff    <= '0;
      end else begin
         rem_ff     <= rem_in;
         total_ff   <= total_in;
         partial_ff <= partial_in;
         lead_ff    <= lead_in;
         cidx_ff    <= cidx_in;
      end
   end

endmodule

@@ sv/utf8p_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8p_queue
// Small event FIFO between the decoder front end and the position tracker.
// ----------------------------------------------------------------------------
module utf8p_queue
   import utf8p_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  utf8p_event_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output utf8p_event_type pop_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

   utf8p_event_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]  rptr_ff, rptr_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full      = (cnt_ff == DEPTH_CNT);
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slot_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

@@ sv/utf8p_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8p_back
// Position tracker: saturating line and column counters and result register.
// ----------------------------------------------------------------------------
module utf8p_back
   import utf8p_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  evt_valid,
   input  utf8p_event_type       evt_data,
   output logic                  evt_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output utf8p_event_type       out_evt,
   output logic [POS_BITS-1:0]   out_line,
   output logic [POS_BITS-1:0]   out_column
);

   logic [COUNTER_BITS-1:0] lines_ff, lines_in;
   logic [COUNTER_BITS-1:0] column_ff, column_in;
   logic                    valid_ff, valid_in;
   utf8p_event_type         evt_ff;

   assign evt_pop = evt_valid && (!valid_ff || out_ready);

   always_comb begin
      lines_in  = lines_ff;
      column_in = column_ff;
      valid_in  = valid_ff && !out_ready;
      if (evt_pop) begin
         valid_in = 1'b1;
         if (!evt_data.malformed) begin
            if (evt_data.code_point == CP_NEWLINE) begin
               if (lines_ff != '1) begin
                  lines_in = lines_ff + 1'b1;
               end
               column_in = '0;
            end else if (column_ff != '1) begin
               column_in = column_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff  <= '0;
         column_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         lines_ff  <= lines_in;
         column_ff <= column_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         evt_ff <= evt_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_evt   = evt_ff;

   // counters show up on the port as their low 32 bits, zero-extended when narrower
   generate
      if (COUNTER_BITS >= POS_BITS) begin : g_wide
         assign out_line   = lines_ff[POS_BITS-1:0];
         assign out_column = column_ff[POS_BITS-1:0];
      end else begin : g_narrow
         assign out_line   = {{(POS_BITS-COUNTER_BITS){1'b0}}, lines_ff};
         assign out_column = {{(POS_BITS-COUNTER_BITS){1'b0}}, column_ff};
      end
   endgenerate

endmodule

@@ sv/utf8_decoder_with_position.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_position
// Strict UTF-8 byte decoder reporting code point, length, line and column.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  req_*     in    tdata[7:0] data_byte
//  rsp_*     out   tdata: code_point, byte_count, line_count, column_count;
//                  tuser: malformed
//
//  One byte per cycle while the event queue is not full; a result for the byte
//  that ends a character or fails passes front end decode, event queue, result register.
//  A four-entry event queue sits between decoder and position tracker, so
//  req_tready drops only when that queue fills while rsp_tready is low.
//  Synchronous reset clears the decode state, the queue and both counters.
// ----------------------------------------------------------------------------
module utf8_decoder_with_position
   import utf8p_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [20:0] code_point, [23:21] byte_count,
                                    // [55:24] line_count, [87:56] column_count
   output logic        rsp_tuser    // [0] malformed
);

   logic            q_full;
   logic            f_push;
   utf8p_event_type f_evt;
   logic            q_pop;
   logic            q_valid;
   utf8p_event_type q_evt;
   utf8p_event_type r_evt;
   logic [POS_BITS-1:0] r_line;
   logic [POS_BITS-1:0] r_column;

   utf8p_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .byte_data  (req_tdata),
      .queue_full (q_full),
      .evt_push   (f_push),
      .evt_data   (f_evt)
   );

   utf8p_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_evt),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_evt)
   );

   utf8p_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (q_valid),
      .evt_data   (q_evt),
      .evt_pop    (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_evt    (r_evt),
      .out_line   (r_line),
      .out_column (r_column)
   );

   assign rsp_tdata = {r_column, r_line, r_evt.byte_count, r_evt.code_point};
   assign rsp_tuser = r_evt.malformed;

   // an error result carries no code point and no length
   a_err_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[23:0] == 24'd0)
      else $error("error result with nonzero code point or length");

   // a decoded character is a scalar value of one to four bytes
   a_char_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[23:21] != 3'd0 && rsp_tdata[23:21] <= MAX_SEQ_BYTES
         && rsp_tdata[20:0] <= CP_MAX)
      else $error("decoded character out of range");

   // the front end never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      f_push |-> !q_full)
      else $error("event pushed while queue full");

   // a queued event is taken whenever the result register is free
   a_drain : assert property (@(posedge clock) disable iff (reset)
      q_valid && !rsp_tvalid |=> rsp_tvalid)
      else $error("queued event not moved to result register");

endmodule
